// File: rtl/core/pcmrms_pkg.sv
// Package for the PCM RMS and peak level meter.
// Holds widths, step counts, the controller state type and the command and status structs.
// Depends on nothing.
package pcmrms_pkg;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned LEVEL_W     = 15;
   localparam int unsigned SQUARE_W    = 31;
   localparam int unsigned SUM_W       = 51;
   localparam int unsigned CNT_W       = 21;
   localparam int unsigned MAX_SAMPLES = 1048576;
   localparam int unsigned ROOT_W      = 32;
   localparam int unsigned ROOT_IN_W   = 31;
   localparam int unsigned DIV_STEPS   = SUM_W;
   localparam int unsigned ROOT_STEPS  = 16;
   localparam int unsigned STEP_W      = 6;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 32;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_DIV,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic flush;
      logic div_step;
      logic root_load;
      logic root_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/pcmrms_ctrl.sv
// Controller of the PCM level meter: accumulate, divide, square root, deliver.
// Depends on pcmrms_pkg; drives the datapath only through cmd_type and reads status_type.
module pcmrms_ctrl
   import pcmrms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   input  status_type status,
   output logic       req_tready,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              div_last;
   logic              root_last;

   assign div_last  = (cnt_ff == STEP_W'(DIV_STEPS - 1));
   assign root_last = (cnt_ff == STEP_W'(ROOT_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      case (state_ff)
         ST_ACCUM: begin
            if (req_tvalid && req_tlast) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_ROOT_LOAD;
            else          cnt_in   = cnt_ff + STEP_W'(1);
         end
         ST_ROOT_LOAD: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_last) state_in = ST_DONE;
            else           cnt_in   = cnt_ff + STEP_W'(1);
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_ACCUM;
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_FLUSH:     cmd.flush     = 1'b1;
         ST_DIV:       cmd.div_step  = 1'b1;
         ST_ROOT_LOAD: cmd.root_load = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_DONE:      cmd.out_load  = status.out_free;
         default:      cmd           = '0;
      endcase
   end

endmodule

// File: rtl/core/pcmrms_dp.sv
// Datapath of the PCM level meter: square and accumulate, restoring divider,
// bit-pair square root and the result register. Depends on pcmrms_pkg.
module pcmrms_dp
   import pcmrms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [SAMPLE_W-1:0]   sample,
   input  logic                  rsp_tready,
   output status_type            status,
   output logic                  rsp_tvalid,
   output logic [LEVEL_W-1:0]    rms_level,
   output logic [LEVEL_W-1:0]    peak_level
);

   // accumulation
   logic [SAMPLE_W-1:0]   mag;
   logic [LEVEL_W-1:0]    pk;
   logic [2*SAMPLE_W-1:0] product;
   logic [SQUARE_W-1:0]   sq_ff;
   logic                  sq_vld_ff, sq_vld_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SUM_W-1:0]      sq_term;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LEVEL_W-1:0]    peak_ff, peak_in;
   logic                  room;

   // divider
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      div_ff;
   logic [CNT_W:0]        trial;
   logic [CNT_W+1:0]      diff;
   logic                  div_ge;

   // square root
   logic [ROOT_W-1:0]     rv_ff, rv_in;
   logic [ROOT_W-1:0]     res_ff, res_in;
   logic [ROOT_W-1:0]     bit_ff, bit_in;
   logic [ROOT_W-1:0]     res_bit;

   logic [LEVEL_W-1:0]    peak_hold_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]    rms_ff;
   logic [LEVEL_W-1:0]    peak_out_ff;

   // -32768 negates to 0x8000, read as unsigned 32768
   assign mag     = sample[SAMPLE_W-1] ? SAMPLE_W'(~sample + SAMPLE_W'(1)) : sample;
   assign pk      = mag[SAMPLE_W-1] ? LEVEL_MAX : mag[LEVEL_W-1:0];
   assign product = mag * mag;
   assign room    = (count_ff < CNT_W'(MAX_SAMPLES));
   assign sq_term = sq_vld_ff ? {{(SUM_W-SQUARE_W){1'b0}}, sq_ff} : '0;

   always_comb begin
      sq_vld_in = cmd.accept && room;
      sum_in    = cmd.flush ? '0 : sum_ff + sq_term;
      count_in  = count_ff;
      peak_in   = peak_ff;
      if (cmd.flush) begin
         count_in = '0;
         peak_in  = '0;
      end else if (cmd.accept) begin
         if (room) count_in = count_ff + CNT_W'(1);
         if (pk > peak_ff) peak_in = pk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         sum_ff    <= '0;
         count_ff  <= '0;
         peak_ff   <= '0;
      end else begin
         sq_vld_ff <= sq_vld_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         peak_ff   <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) sq_ff <= product[SQUARE_W-1:0];
   end

   // one quotient bit per step, dividend shifted out of quo_ff from the top
   assign trial  = {rem_ff, quo_ff[SUM_W-1]};
   assign diff   = {1'b0, trial} - {2'b00, div_ff};
   assign div_ge = !diff[CNT_W+1];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.flush) begin
         quo_in = sum_ff + sq_term;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[SUM_W-2:0], div_ge};
         rem_in = div_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.flush) begin
         div_ff       <= count_ff;
         peak_hold_ff <= peak_ff;
      end
   end

   // the mean never exceeds 2^30, so the root needs sixteen bit pairs
   assign res_bit = res_ff + bit_ff;

   always_comb begin
      rv_in  = rv_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (cmd.root_load) begin
         rv_in  = {{(ROOT_W-ROOT_IN_W){1'b0}}, quo_ff[ROOT_IN_W-1:0]};
         res_in = '0;
         bit_in = ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
      end else if (cmd.root_step) begin
         if (rv_ff >= res_bit) begin
            rv_in  = rv_ff - res_bit;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      rv_ff  <= rv_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   // result register: frees the controller while a result waits
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rms_ff      <= (res_ff > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : res_ff[LEVEL_W-1:0];
         peak_out_ff <= peak_hold_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rms_level  = rms_ff;
   assign peak_level = peak_out_ff;

endmodule

// File: rtl/core/pcm_rms_peak_meter_unit.sv
// Top level of the PCM RMS and peak level meter.
// Depends on pcmrms_pkg, pcmrms_ctrl and pcmrms_dp.
//
//   channel | dir | tdata                               | tlast
//   req_    | in  | [15:0] sample (signed)              | is_last
//   rsp_    | out | [14:0] rms_level, [29:15] peak_level | -
//
// Samples are taken one a cycle while the input is open; squaring sits one stage ahead of the 51-bit sum.
// A beat with tlast closes the input; the controller then closes the sum, runs the
// one-bit-a-cycle divider, loads and runs the square root, and loads the result.
// Reset is synchronous and clears the sums, count, peak and the result valid.
// A result held by a stalled rsp_ side does not block the next buffer; only the
// following result waits for it.
module pcm_rms_peak_meter_unit
   import pcmrms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] sample
   input  logic                  req_tlast,   // is_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [14:0] rms_level, [29:15] peak_level, zero above
);

   cmd_type            cmd;
   status_type         status;
   logic [LEVEL_W-1:0] rms_level;
   logic [LEVEL_W-1:0] peak_level;

   pcmrms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   pcmrms_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample     (req_tdata[SAMPLE_W-1:0]),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rms_level  (rms_level),
      .peak_level (peak_level)
   );

   assign rsp_tdata = {{(RSP_DATA_W-2*LEVEL_W){1'b0}}, peak_level, rms_level};

   // the end of a buffer closes the input until its result is loaded
   a_last_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after the last beat of a buffer");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a stalled beat");

   // a result only appears after the controller has loaded one
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result valid without a load");

endmodule
